// ===== src/lsps_pkg.sv =====
`timescale 1ns / 1ps
// lsps_pkg: shared types, colour codes, csr indexes and the palette lookup
// for the led strip pixel serializer. no dependencies.
package lsps_pkg;

   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int STEP_W      = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0]  GLOBAL_RESET = 8'hE1;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 11'd340;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLOBAL_BYTE = 2'd0,
      CSR_PIXEL_COUNT = 2'd1
   } csr_index_type;

   localparam logic [BYTE_W-1:0] CODE_OFF    = 8'h20;
   localparam logic [BYTE_W-1:0] CODE_RED    = 8'h72;
   localparam logic [BYTE_W-1:0] CODE_ORANGE = 8'h6F;
   localparam logic [BYTE_W-1:0] CODE_YELLOW = 8'h79;
   localparam logic [BYTE_W-1:0] CODE_GREEN  = 8'h67;
   localparam logic [BYTE_W-1:0] CODE_BLUE   = 8'h62;
   localparam logic [BYTE_W-1:0] CODE_VIOLET = 8'h76;
   localparam logic [BYTE_W-1:0] CODE_WHITE  = 8'h31;

   // byte slots of one pixel; slots below STEP_GLOBAL are start frame bytes
   localparam logic [STEP_W-1:0] STEP_FIRST  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_GLOBAL = 3'd4;
   localparam logic [STEP_W-1:0] STEP_BLUE   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_GREEN  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_RED    = 3'd7;

   typedef struct packed {
      logic              known;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
   } color_type;

   typedef struct packed {
      logic              start;
      logic [BYTE_W-1:0] global_byte;
      color_type         color;
   } cmd_type;

   function automatic color_type palette(input logic [BYTE_W-1:0] code);
      color_type c;
      c = '{known: 1'b1, blue: 8'h00, green: 8'h00, red: 8'h00};
      unique case (code)
         CODE_OFF:    ;
         CODE_RED:    c.red = 8'hFF;
         CODE_ORANGE: begin
            c.green = 8'h3D;
            c.red   = 8'hFF;
         end
         CODE_YELLOW: begin
            c.green = 8'hEA;
            c.red   = 8'hFF;
         end
         CODE_GREEN:  c.green = 8'hFF;
         CODE_BLUE:   c.blue = 8'hFF;
         CODE_VIOLET: begin
            c.blue = 8'h6B;
            c.red  = 8'h38;
         end
         CODE_WHITE:  begin
            c.blue  = 8'hFF;
            c.green = 8'hFF;
            c.red   = 8'hFF;
         end
         default:     c.known = 1'b0;
      endcase
      return c;
   endfunction

endpackage

// ===== src/led_strip_pixel_serializer.sv =====
`timescale 1ns / 1ps
// led_strip_pixel_serializer: top level, front + command queue + byte sequencer.
// depends on lsps_pkg, lsps_front, lsps_queue, lsps_back.
//
//   channel | ports                                        | beat
//   --------+----------------------------------------------+-----------------
//   req     | req_push, req_full, req_color_code           | one pixel
//   rsp     | rsp_empty, rsp_pop, rsp_tx_byte, rsp_*        | one strip byte
//   csr     | csr_valid, csr_ready, csr_index, csr_data    | one register write
//
// one result byte per cycle while rsp is popped and a command waits: a pixel takes 4 bytes,
// 8 at the first pixel of a frame (start frame), 1 for an unknown code and 5 for an unknown
// code at the first pixel of a frame; the byte sequencer sets the rate.
// the two-entry command queue lets the front take pixels while rsp stalls.
// reset is synchronous: brightness 0xE1, pixel count 340, pixel index 0.
module led_strip_pixel_serializer #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [lsps_pkg::BYTE_W-1:0]    req_color_code,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [lsps_pkg::BYTE_W-1:0]    rsp_tx_byte,
   output logic                           rsp_is_start_frame,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lsps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsps_pkg::COUNT_W-1:0]   csr_data
);
   import lsps_pkg::*;

   logic    q_push, q_full, q_pop, q_valid;
   cmd_type q_wr_data, q_rd_data;

   assign req_full = q_full;

   lsps_front #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_color_code (req_color_code),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_wr_data),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .csr_ready      (csr_ready)
   );

   lsps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_data  (q_rd_data),
      .nonempty (q_valid)
   );

   lsps_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_rd_data),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_is_start_frame (rsp_is_start_frame),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== src/lsps_front.sv =====
`timescale 1ns / 1ps
// lsps_front: csr registers, colour classification and pixel position counter.
// depends on lsps_pkg.
module lsps_front #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [lsps_pkg::BYTE_W-1:0]   req_color_code,
   input  logic                          q_full,
   output logic                          q_push,
   output lsps_pkg::cmd_type             q_data,
   input  logic                          csr_valid,
   input  logic [lsps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsps_pkg::COUNT_W-1:0]  csr_data,
   output logic                          csr_ready
);
   import lsps_pkg::*;

   localparam int IDX_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int MAX_W  = $clog2(MAX_PIXELS + 1);
   localparam int CMP_W  = (MAX_W > COUNT_W) ? MAX_W : COUNT_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PIXELS);

   logic [BYTE_W-1:0]  global_ff, global_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic [CMP_W-1:0]   count_wide, count_eff, next_wide;
   logic               csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign q_push    = req_push & ~q_full;

   always_comb begin
      global_in = global_ff;
      count_in  = count_ff;
      if (csr_wr && csr_index == CSR_GLOBAL_BYTE) begin
         global_in = csr_data[BYTE_W-1:0];
      end
      if (csr_wr && csr_index == CSR_PIXEL_COUNT) begin
         count_in = csr_data;
      end
   end

   // zero counts as one, above the maximum saturates
   always_comb begin
      count_wide = CMP_W'(count_ff);
      count_eff  = count_wide;
      priority if (count_wide == '0) begin
         count_eff = CMP_W'(1);
      end else if (count_wide > MAX_CMP) begin
         count_eff = MAX_CMP;
      end
      next_wide = CMP_W'(index_ff) + CMP_W'(1);
   end

   always_comb begin
      index_in = index_ff;
      if (q_push) begin
         index_in = (next_wide >= count_eff) ? '0 : next_wide[IDX_W-1:0];
      end
   end

   always_comb begin
      q_data.start       = (index_ff == '0);
      q_data.global_byte = global_ff;
      q_data.color       = palette(req_color_code);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_ff <= GLOBAL_RESET;
         count_ff  <= COUNT_RESET;
         index_ff  <= '0;
      end else begin
         global_ff <= global_in;
         count_ff  <= count_in;
         index_ff  <= index_in;
      end
   end

endmodule

// ===== src/lsps_queue.sv =====
`timescale 1ns / 1ps
// lsps_queue: short command queue between front and back.
// depends on lsps_pkg.
module lsps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  lsps_pkg::cmd_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output lsps_pkg::cmd_type rd_data,
   output logic              nonempty
);
   import lsps_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == DEPTH_CNT);
   assign nonempty = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/lsps_back.sv =====
`timescale 1ns / 1ps
// lsps_back: byte sequencer that walks one command per pixel and fills the
// result register. depends on lsps_pkg.
module lsps_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  lsps_pkg::cmd_type           q_data,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [lsps_pkg::BYTE_W-1:0] rsp_tx_byte,
   output logic                        rsp_is_start_frame,
   output logic                        rsp_last
);
   import lsps_pkg::*;

   cmd_type           cmd_ff, cmd_in;
   logic              active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              start_ff, start_in;
   logic              last_ff, last_in;
   logic              advance, in_start, is_last;
   logic [BYTE_W-1:0] cur_byte;

   assign advance  = active_ff & (~valid_ff | rsp_pop);
   assign in_start = (step_ff < STEP_GLOBAL);
   assign is_last  = (step_ff == STEP_RED)
                   | ((step_ff == STEP_GLOBAL) & ~cmd_ff.color.known);
   assign q_pop    = q_valid & (~active_ff | (advance & is_last));

   always_comb begin
      unique case (step_ff)
         STEP_GLOBAL: cur_byte = cmd_ff.global_byte;
         STEP_BLUE:   cur_byte = cmd_ff.color.blue;
         STEP_GREEN:  cur_byte = cmd_ff.color.green;
         STEP_RED:    cur_byte = cmd_ff.color.red;
         default:     cur_byte = '0;
      endcase
   end

   always_comb begin
      cmd_in    = cmd_ff;
      active_in = active_ff;
      step_in   = step_ff;
      valid_in  = valid_ff & ~rsp_pop;
      byte_in   = byte_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      if (advance) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         start_in = in_start;
         last_in  = is_last;
         step_in  = step_ff + STEP_W'(1);
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (q_pop) begin
         cmd_in    = q_data;
         active_in = 1'b1;
         step_in   = q_data.start ? STEP_FIRST : STEP_GLOBAL;
      end
   end

   assign rsp_empty          = ~valid_ff;
   assign rsp_tx_byte        = byte_ff;
   assign rsp_is_start_frame = start_ff;
   assign rsp_last           = last_ff;

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
      start_ff <= start_in;
      last_ff <= last_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

// ===== src/lsps_checker.sv =====
`timescale 1ns / 1ps
// lsps_checker: port-level assertions for led_strip_pixel_serializer, bound
// to the top level. depends on lsps_pkg.
module lsps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_push,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [lsps_pkg::BYTE_W-1:0] rsp_tx_byte,
   input logic                        rsp_is_start_frame,
   input logic                        rsp_last
);

   // a waiting beat holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_tx_byte)
         && $stable(rsp_is_start_frame) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_is_start_frame |-> rsp_tx_byte == '0 && !rsp_last)
      else $error("start frame beat not a zero non-last byte");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not empty after reset");

   // a popped non-last beat is followed right away by the next beat of its pixel
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_last |=> !rsp_empty)
      else $error("pixel byte sequence broken");

   a_push_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_push |-> !req_full)
      else $error("full without any push after reset");

endmodule

bind led_strip_pixel_serializer lsps_checker u_lsps_checker (
   .clock              (clock),
   .reset              (reset),
   .req_push           (req_push),
   .req_full           (req_full),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_tx_byte        (rsp_tx_byte),
   .rsp_is_start_frame (rsp_is_start_frame),
   .rsp_last           (rsp_last)
);
